>>> design/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg - shared types and constants for the integer to radix text core
// Control word layout, microcode step names and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int LEN_W       = 6;

	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W     = DIV_STEPS * DIV_BITS;
	localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam int ADDR_W    = $clog2(VALUE_WIDTH);
	localparam int STACK_D   = 2 ** ADDR_W;
	localparam int PTR_W     = ADDR_W + 1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

	localparam int UPC_W = 3;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t STEP_IDLE  = 3'd0;
	localparam upc_t STEP_DIV   = 3'd1;
	localparam upc_t STEP_PUSH  = 3'd2;
	localparam upc_t STEP_SIGN  = 3'd3;
	localparam upc_t STEP_READ  = 3'd4;
	localparam upc_t STEP_DIGIT = 3'd5;
	localparam upc_t STEP_DONE  = 3'd6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_PUSH,
		OP_SIGN,
		OP_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_DIV_MORE,
		COND_QUOT_NZ,
		COND_SIGN_WAIT,
		COND_SLOT_BUSY,
		COND_MULTI_DIGITS
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t hold;
		cond_t jump;
		upc_t  target;
	} ctl_word_t;

	typedef struct packed {
		logic no_input;
		logic div_more;
		logic quot_nz;
		logic sign_wait;
		logic slot_busy;
		logic multi_digits;
	} dp_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		if (dw > CHAR_W'(9)) begin
			digit_char = dw - CHAR_W'(10) + CHAR_A;
		end else begin
			digit_char = dw + CHAR_ZERO;
		end
	endfunction

endpackage

`default_nettype wire

>>> design/itra_sequencer.sv
// ----------------------------------------------------------------------------
// itra_sequencer - microcode store and step counter
// One control word per step; hold and jump conditions come from the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_sequencer
	import itra_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  dp_status_t status,
	output ctl_word_t  cw
);

	upc_t upc_q;
	upc_t upc_next;
	logic hold_hit;
	logic jump_hit;

	function automatic ctl_word_t rom(input upc_t a);
		ctl_word_t w;
		w = '{op: OP_NONE, hold: COND_NEVER, jump: COND_ALWAYS, target: STEP_IDLE};
		case (a)
			STEP_IDLE:  w = '{op: OP_LOAD,  hold: COND_NO_INPUT,  jump: COND_NEVER,
			                  target: STEP_IDLE};
			STEP_DIV:   w = '{op: OP_DIV,   hold: COND_DIV_MORE,  jump: COND_NEVER,
			                  target: STEP_IDLE};
			STEP_PUSH:  w = '{op: OP_PUSH,  hold: COND_NEVER,     jump: COND_QUOT_NZ,
			                  target: STEP_DIV};
			STEP_SIGN:  w = '{op: OP_SIGN,  hold: COND_SIGN_WAIT, jump: COND_NEVER,
			                  target: STEP_IDLE};
			STEP_READ:  w = '{op: OP_NONE,  hold: COND_NEVER,     jump: COND_NEVER,
			                  target: STEP_IDLE};
			STEP_DIGIT: w = '{op: OP_DIGIT, hold: COND_SLOT_BUSY, jump: COND_MULTI_DIGITS,
			                  target: STEP_READ};
			STEP_DONE:  w = '{op: OP_NONE,  hold: COND_NEVER,     jump: COND_ALWAYS,
			                  target: STEP_IDLE};
			default:    w = '{op: OP_NONE,  hold: COND_NEVER,     jump: COND_ALWAYS,
			                  target: STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic test(input cond_t c, input dp_status_t s);
		logic r;
		case (c)
			COND_NEVER:        r = 1'b0;
			COND_ALWAYS:       r = 1'b1;
			COND_NO_INPUT:     r = s.no_input;
			COND_DIV_MORE:     r = s.div_more;
			COND_QUOT_NZ:      r = s.quot_nz;
			COND_SIGN_WAIT:    r = s.sign_wait;
			COND_SLOT_BUSY:    r = s.slot_busy;
			COND_MULTI_DIGITS: r = s.multi_digits;
			default:           r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		cw       = rom(upc_q);
		hold_hit = test(cw.hold, status);
		jump_hit = test(cw.jump, status);
		if (hold_hit) begin
			upc_next = upc_q;
		end else if (jump_hit) begin
			upc_next = cw.target;
		end else begin
			upc_next = upc_q + upc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	a_upc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= STEP_DONE)
		else $error("step counter left the program");

	a_done_returns: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == STEP_DONE |=> upc_q == STEP_IDLE)
		else $error("done step did not return to idle");

	a_push_branch: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == STEP_PUSH |=> (upc_q == STEP_DIV || upc_q == STEP_SIGN))
		else $error("bad branch after digit push");

endmodule

`default_nettype wire

>>> design/itra_datapath.sv
// ----------------------------------------------------------------------------
// itra_datapath - magnitude, chunked divider, digit stack and output register
// Executes the op of the current control word and reports branch conditions.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_datapath
	import itra_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  ctl_word_t              cw,
	output dp_status_t             status,
	input  wire                    cfg_valid,
	input  wire [RADIX_W-1:0]      cfg_data,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [VALUE_WIDTH-1:0]  in_value,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [CHAR_W-1:0]      out_char,
	output logic [LEN_W-1:0]       out_len,
	output logic                   out_last
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base;
	logic [DIV_W-1:0]   work_q;
	logic [RADIX_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [PTR_W-1:0]   sp_q;
	logic [LEN_W-1:0]   len_q;
	logic [CHAR_W-1:0]  stack_mem [STACK_D];
	logic [CHAR_W-1:0]  rd_q;
	logic [ADDR_W-1:0]  rd_addr;

	logic               accept;
	logic               slot_free;
	logic               sign_fire;
	logic               digit_fire;
	logic [VALUE_WIDTH-1:0] mag;
	logic [DIV_W-1:0]   work_next;
	logic [RADIX_W-1:0] rem_next;
	logic [RADIX_W:0]   part;

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign in_ready   = (cw.op == OP_LOAD);
	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid || out_ready;
	assign sign_fire  = (cw.op == OP_SIGN) && neg_q && slot_free;
	assign digit_fire = (cw.op == OP_DIGIT) && slot_free;
	assign mag        = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
	assign rd_addr    = ADDR_W'(sp_q - PTR_W'(1));

	// restoring division, DIV_BITS quotient bits per cycle, MSB first
	always_comb begin
		rem_next  = rem_q;
		work_next = work_q;
		part      = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			part      = {rem_next, work_next[DIV_W-1]};
			work_next = {work_next[DIV_W-2:0], 1'b0};
			if (part >= {1'b0, base}) begin
				part         = part - {1'b0, base};
				work_next[0] = 1'b1;
			end
			rem_next = part[RADIX_W-1:0];
		end
	end

	always_comb begin
		status.no_input     = !in_valid;
		status.div_more     = (cnt_q != CNT_LAST);
		status.quot_nz      = (work_q != '0);
		status.sign_wait    = neg_q && !slot_free;
		status.slot_busy    = !slot_free;
		status.multi_digits = (sp_q != PTR_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q   <= RADIX_RESET;
			rem_q     <= '0;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= cfg_data;
			end
			case (cw.op)
				OP_LOAD: begin
					if (accept) begin
						neg_q <= in_value[VALUE_WIDTH-1];
						rem_q <= '0;
						cnt_q <= '0;
						sp_q  <= '0;
					end
				end
				OP_DIV: begin
					rem_q <= rem_next;
					cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
				end
				OP_PUSH: begin
					rem_q <= '0;
					sp_q  <= sp_q + PTR_W'(1);
				end
				OP_DIGIT: begin
					if (digit_fire) begin
						sp_q <= sp_q - PTR_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (sign_fire || digit_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_q <= DIV_W'(mag);
		end else if (cw.op == OP_DIV) begin
			work_q <= work_next;
		end
		if (cw.op == OP_PUSH) begin
			len_q <= LEN_W'(sp_q + PTR_W'(1) + PTR_W'(neg_q));
		end
		if (sign_fire) begin
			out_char <= CHAR_MINUS;
			out_len  <= len_q;
			out_last <= (len_q == LEN_W'(1));
		end else if (digit_fire) begin
			out_char <= rd_q;
			out_len  <= len_q;
			out_last <= (sp_q == PTR_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_PUSH) begin
			stack_mem[sp_q[ADDR_W-1:0]] <= digit_char(rem_q);
		end
		rd_q <= stack_mem[rd_addr];
	end

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> sp_q == '0 && !out_valid || accept && sp_q == '0)
		else $error("new value taken while digits remain on the stack");

	a_digit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		digit_fire |-> sp_q != '0)
		else $error("digit emitted from an empty stack");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		cw.op == OP_DIV |=> rem_q < base)
		else $error("division remainder not below the base");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PTR_W'(VALUE_WIDTH))
		else $error("digit stack overflow");

endmodule

`default_nettype wire

>>> design/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core - signed integer to ASCII text in base 2..36
// Microcoded converter: divides by the base one digit at a time, stacks the
// digits, then streams the text most significant character first.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_axis   in   s_tvalid/s_tready     s_tdata[31:0] value
//  m_axis   out  m_tvalid/m_tready     m_tdata character, text_length; m_tlast
//  cfg      in   cfg_valid/cfg_ready   cfg_data[5:0] radix
//
//  Conversion time is set by the 8-bit-per-cycle divider (DIV_STEPS = 4 at 32
//  bits) and by the registered digit stack read before each emitted digit.
//  Reset clears the radix to 10 and the step counter to idle.
//  A stalled sink holds the sequencer at the sign or digit emit step; s_tready
//  is high only in the idle step.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii_core
	import itra_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [5:0]  cfg_data,   // [5:0] radix
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,    // [31:0] value
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,    // [6:0] character, [12:7] text_length, [15:13] zero
	output logic        m_tlast
);

	ctl_word_t         cw;
	dp_status_t        status;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_len;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {3'b000, out_len, out_char};

	itra_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw)
	);

	itra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_len   (out_len),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
